/* rtl/c8ae_pkg.sv */
// Shared types, command codes and flag positions for the 8-bit ALU execute block.
`default_nettype none

package c8ae_pkg;

  localparam int unsigned CmdW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SaddrW = 9;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 56;

  // Status bit positions (NV1BDIZC)
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] ResetSp     = 8'hFD;
  localparam logic [7:0] ResetStatus = 8'h24;

  typedef enum logic [CmdW-1:0] {
    CMD_NOP = 6'd0,  CMD_ADC = 6'd1,  CMD_SBC = 6'd2,  CMD_AND = 6'd3,
    CMD_ORA = 6'd4,  CMD_EOR = 6'd5,  CMD_CMP = 6'd6,  CMD_CPX = 6'd7,
    CMD_CPY = 6'd8,  CMD_BIT = 6'd9,  CMD_LDA = 6'd10, CMD_LDX = 6'd11,
    CMD_LDY = 6'd12, CMD_STA = 6'd13, CMD_STX = 6'd14, CMD_STY = 6'd15,
    CMD_TAX = 6'd16, CMD_TAY = 6'd17, CMD_TXA = 6'd18, CMD_TYA = 6'd19,
    CMD_TSX = 6'd20, CMD_TXS = 6'd21, CMD_INC = 6'd22, CMD_DEC = 6'd23,
    CMD_INX = 6'd24, CMD_INY = 6'd25, CMD_DEX = 6'd26, CMD_DEY = 6'd27,
    CMD_ASL = 6'd28, CMD_LSR = 6'd29, CMD_ROL = 6'd30, CMD_ROR = 6'd31,
    CMD_CLC = 6'd32, CMD_SEC = 6'd33, CMD_CLI = 6'd34, CMD_SEI = 6'd35,
    CMD_CLD = 6'd36, CMD_SED = 6'd37, CMD_CLV = 6'd38, CMD_PHA = 6'd39,
    CMD_PHP = 6'd40, CMD_PLA = 6'd41, CMD_PLP = 6'd42, CMD_BCC = 6'd43,
    CMD_BCS = 6'd44, CMD_BEQ = 6'd45, CMD_BNE = 6'd46, CMD_BMI = 6'd47,
    CMD_BPL = 6'd48, CMD_BVC = 6'd49, CMD_BVS = 6'd50
  } cmd_e;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_t;

  typedef struct packed {
    logic [7:0]        write_data;
    logic              write_valid;
    logic              stack_access;
    logic [SaddrW-1:0] stack_address;
    logic              branch_taken;
  } side_t;

endpackage

`default_nettype wire

/* rtl/c8ae_alu.sv */
// Combinational execute step: next register set and side outputs for one command.
`default_nettype none

module c8ae_alu (
  input  logic [c8ae_pkg::CmdW-1:0]  cmd_i,
  input  logic [c8ae_pkg::ByteW-1:0] operand_i,
  input  logic                       on_memory_i,
  input  c8ae_pkg::arch_t            cur_i,
  output c8ae_pkg::arch_t            nxt_o,
  output c8ae_pkg::side_t            side_o
);
  import c8ae_pkg::*;

  logic [7:0] src;
  logic [7:0] addend;
  logic [8:0] sum;
  logic       add_ovf;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sp_inc;
  logic [7:0] sp_dec;

  assign src      = on_memory_i ? operand_i : cur_i.a;
  assign addend   = (cmd_e'(cmd_i) == CMD_SBC) ? ~operand_i : operand_i;
  assign sum      = {1'b0, cur_i.a} + {1'b0, addend} + {8'b0, cur_i.p[FlagC]};
  assign add_ovf  = ~(cur_i.a[7] ^ addend[7]) & (cur_i.a[7] ^ sum[7]);
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand_i};
  assign sp_inc   = cur_i.sp + 8'd1;
  assign sp_dec   = cur_i.sp - 8'd1;

  always_comb begin
    unique case (cmd_e'(cmd_i))
      CMD_CPX: cmp_reg = cur_i.x;
      CMD_CPY: cmp_reg = cur_i.y;
      default: cmp_reg = cur_i.a;
    endcase
  end

  always_comb begin
    arch_t      n;
    logic [7:0] v;
    logic       nz_en;
    logic       rmw;
    n      = cur_i;
    v      = 8'd0;
    nz_en  = 1'b0;
    rmw    = 1'b0;
    side_o = '0;
    unique case (cmd_e'(cmd_i))
      CMD_ADC, CMD_SBC: begin
        n.a          = sum[7:0];
        n.p[FlagC]   = sum[8];
        n.p[FlagV]   = add_ovf;
        v            = sum[7:0];
        nz_en        = 1'b1;
      end
      CMD_AND: begin n.a = cur_i.a & operand_i; v = n.a; nz_en = 1'b1; end
      CMD_ORA: begin n.a = cur_i.a | operand_i; v = n.a; nz_en = 1'b1; end
      CMD_EOR: begin n.a = cur_i.a ^ operand_i; v = n.a; nz_en = 1'b1; end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        n.p[FlagC] = ~cmp_diff[8];
        v          = cmp_diff[7:0];
        nz_en      = 1'b1;
      end
      CMD_BIT: begin
        n.p[FlagZ] = ((cur_i.a & operand_i) == 8'd0);
        n.p[FlagN] = operand_i[7];
        n.p[FlagV] = operand_i[6];
      end
      CMD_LDA: begin n.a = operand_i; v = operand_i; nz_en = 1'b1; end
      CMD_LDX: begin n.x = operand_i; v = operand_i; nz_en = 1'b1; end
      CMD_LDY: begin n.y = operand_i; v = operand_i; nz_en = 1'b1; end
      CMD_STA: begin side_o.write_data = cur_i.a; side_o.write_valid = 1'b1; end
      CMD_STX: begin side_o.write_data = cur_i.x; side_o.write_valid = 1'b1; end
      CMD_STY: begin side_o.write_data = cur_i.y; side_o.write_valid = 1'b1; end
      CMD_TAX: begin n.x = cur_i.a;  v = cur_i.a;  nz_en = 1'b1; end
      CMD_TAY: begin n.y = cur_i.a;  v = cur_i.a;  nz_en = 1'b1; end
      CMD_TXA: begin n.a = cur_i.x;  v = cur_i.x;  nz_en = 1'b1; end
      CMD_TYA: begin n.a = cur_i.y;  v = cur_i.y;  nz_en = 1'b1; end
      CMD_TSX: begin n.x = cur_i.sp; v = cur_i.sp; nz_en = 1'b1; end
      CMD_TXS: n.sp = cur_i.x;
      CMD_INC: begin v = src + 8'd1; rmw = 1'b1; end
      CMD_DEC: begin v = src - 8'd1; rmw = 1'b1; end
      CMD_ASL: begin
        n.p[FlagC] = src[7];
        v          = {src[6:0], 1'b0};
        rmw        = 1'b1;
      end
      CMD_LSR: begin
        n.p[FlagC] = src[0];
        v          = {1'b0, src[7:1]};
        rmw        = 1'b1;
      end
      CMD_ROL: begin
        n.p[FlagC] = src[7];
        v          = {src[6:0], cur_i.p[FlagC]};
        rmw        = 1'b1;
      end
      CMD_ROR: begin
        n.p[FlagC] = src[0];
        v          = {cur_i.p[FlagC], src[7:1]};
        rmw        = 1'b1;
      end
      CMD_INX: begin n.x = cur_i.x + 8'd1; v = n.x; nz_en = 1'b1; end
      CMD_INY: begin n.y = cur_i.y + 8'd1; v = n.y; nz_en = 1'b1; end
      CMD_DEX: begin n.x = cur_i.x - 8'd1; v = n.x; nz_en = 1'b1; end
      CMD_DEY: begin n.y = cur_i.y - 8'd1; v = n.y; nz_en = 1'b1; end
      CMD_CLC: n.p[FlagC] = 1'b0;
      CMD_SEC: n.p[FlagC] = 1'b1;
      CMD_CLI: n.p[FlagI] = 1'b0;
      CMD_SEI: n.p[FlagI] = 1'b1;
      CMD_CLD: n.p[FlagD] = 1'b0;
      CMD_SED: n.p[FlagD] = 1'b1;
      CMD_CLV: n.p[FlagV] = 1'b0;
      CMD_PHA, CMD_PHP: begin
        side_o.write_data   = (cmd_e'(cmd_i) == CMD_PHA) ? cur_i.a
                                                         : (cur_i.p | 8'h30);
        side_o.write_valid  = 1'b1;
        side_o.stack_access = 1'b1;
        n.sp                = sp_dec;
      end
      CMD_PLA: begin
        side_o.stack_access = 1'b1;
        n.sp                = sp_inc;
        n.a                 = operand_i;
        v                   = operand_i;
        nz_en               = 1'b1;
      end
      CMD_PLP: begin
        side_o.stack_access = 1'b1;
        n.sp                = sp_inc;
        n.p                 = operand_i;
      end
      CMD_BCC: side_o.branch_taken = ~cur_i.p[FlagC];
      CMD_BCS: side_o.branch_taken =  cur_i.p[FlagC];
      CMD_BEQ: side_o.branch_taken =  cur_i.p[FlagZ];
      CMD_BNE: side_o.branch_taken = ~cur_i.p[FlagZ];
      CMD_BMI: side_o.branch_taken =  cur_i.p[FlagN];
      CMD_BPL: side_o.branch_taken = ~cur_i.p[FlagN];
      CMD_BVC: side_o.branch_taken = ~cur_i.p[FlagV];
      CMD_BVS: side_o.branch_taken =  cur_i.p[FlagV];
      default: n = cur_i;
    endcase

    // read-modify-write lands in memory or the accumulator
    if (rmw) begin
      nz_en = 1'b1;
      if (on_memory_i) begin
        side_o.write_data  = v;
        side_o.write_valid = 1'b1;
      end else begin
        n.a = v;
      end
    end

    if (nz_en) begin
      n.p[FlagZ] = (v == 8'd0);
      n.p[FlagN] = v[7];
    end

    n.p[FlagU] = 1'b1;
    n.p[FlagB] = 1'b0;

    // push uses the pointer before the step, pull the one after it
    if (side_o.stack_access && side_o.write_valid) begin
      side_o.stack_address = {1'b1, cur_i.sp};
    end else begin
      side_o.stack_address = {1'b1, n.sp};
    end

    nxt_o = n;
  end

endmodule

`default_nettype wire

/* rtl/cpu8_alu_register_execute.sv */
// Top level: input register, execute step, register file and result register.
//
// Usage:
//   Slave side (s_axis_*) takes one command item per cycle while s_axis_tready
//   is high: command, operand byte and the on_memory select. Master side
//   (m_axis_*) returns one result item per command: write-back byte and strobe,
//   stack access and address, branch decision, status byte and the A, X and Y
//   registers after the command. An accepted command waits in the input
//   register and executes when the result register is free: its result
//   register loads and A/X/Y/S/P update, and its result is offered from then on.
//   Throughput: one item per cycle while the receiver does not stall, set by the
//   single execute step between the input register and the result register;
//   register updates of one command are visible to the next one when it executes.
//   Reset clears A, X and Y, sets S to 0xFD and P to 0x24, and empties both
//   the input and result registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, and s_axis_tready drops only while both hold.
`default_nettype none

module cpu8_alu_register_execute (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] command, [13:6] operand, [14] on_memory, [15] zero
  input  logic [c8ae_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] write_data, [8] write_valid, [9] stack_access, [18:10] stack_address,
  // [19] branch_taken, [27:20] status_flags, [35:28] accumulator_out,
  // [43:36] index_x_out, [51:44] index_y_out, [55:52] zero
  output logic [c8ae_pkg::OutDataW-1:0]      m_axis_tdata
);
  import c8ae_pkg::*;

  logic             in_v_q;
  logic [CmdW-1:0]  in_cmd_q;
  logic [7:0]       in_opd_q;
  logic             in_mem_q;
  logic             out_v_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;
  arch_t            arch_q;
  arch_t            arch_d;
  side_t            side;
  logic             out_free;
  logic             fire;

  assign out_free      = ~out_v_q | m_axis_tready;
  assign fire          = in_v_q & out_free;
  assign s_axis_tready = ~in_v_q | fire;

  c8ae_alu u_alu (
    .cmd_i       (in_cmd_q),
    .operand_i   (in_opd_q),
    .on_memory_i (in_mem_q),
    .cur_i       (arch_q),
    .nxt_o       (arch_d),
    .side_o      (side)
  );

  assign out_data_d = {4'b0, arch_d.y, arch_d.x, arch_d.a, arch_d.p,
                       side.branch_taken, side.stack_address, side.stack_access,
                       side.write_valid, side.write_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      arch_q  <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: ResetSp, p: ResetStatus};
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_v_q <= in_v_q;
      end
      if (fire) begin
        arch_q <= arch_d;
      end
    end
  end

  // payload registers: input loads on handshake, result on fire, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tdata[5:0];
      in_opd_q <= s_axis_tdata[13:6];
      in_mem_q <= s_axis_tdata[14];
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/c8ae_checker.sv */
// Port-level checker for the execute block, bound to the top level.
`default_nettype none

module c8ae_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [c8ae_pkg::OutDataW-1:0] m_axis_tdata
);
  import c8ae_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // status always shows bit 5 set and B clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20 + FlagU] && !m_axis_tdata[20 + FlagB])
    else $error("status fixed bits wrong");

  // write data is zero unless a write is requested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("write data without write strobe");

  // a taken branch neither writes nor touches the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> !m_axis_tdata[8] && !m_axis_tdata[9])
    else $error("branch with side effect");

  // stack address always lies in page one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18])
    else $error("stack address outside page one");

endmodule

bind cpu8_alu_register_execute c8ae_checker u_c8ae_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/cpu8_alu_register_execute_tb.sv */
// Self-checking testbench for the 8-bit ALU and register execute stage.
`default_nettype none

module cpu8_alu_register_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c8ae_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  // Result item as it appears on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]        pad;
    logic [ByteW-1:0]  index_y;
    logic [ByteW-1:0]  index_x;
    logic [ByteW-1:0]  acc;
    logic [ByteW-1:0]  flags;
    logic              taken;
    logic [SaddrW-1:0] saddr;
    logic              sacc;
    logic              wvalid;
    logic [ByteW-1:0]  wdata;
  } exec_result_t;

  // Tracks A, X, Y, S and P and the results still owed by the block
  class cpu_state_model;
    logic [7:0] a, x, y, sp, p;
    exec_result_t owed_results[$];
    int unsigned errors;
    int unsigned result_idx;

    function new();
      a = 8'h00;
      x = 8'h00;
      y = 8'h00;
      sp = ResetSp;
      p = ResetStatus;
      errors = 0;
      result_idx = 0;
    endfunction

    function logic [7:0] nz(logic [7:0] v);
      p[FlagZ] = (v == 8'h00);
      p[FlagN] = v[7];
      return v;
    endfunction

    function void add_with_carry(logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] r;
      sum = {1'b0, a} + {1'b0, m} + {8'h00, p[FlagC]};
      r = sum[7:0];
      p[FlagC] = sum[8];
      p[FlagV] = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
      a = nz(r);
    endfunction

    function void compare_with(logic [7:0] r, logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      p[FlagC] = (r >= m);
      void'(nz(diff));
    endfunction

    // Advance the register state by one accepted command and owe its result
    function void note_command(logic [5:0] cmd, logic [7:0] opnd, logic on_mem);
      exec_result_t res;
      logic [7:0] v;
      logic cin;
      res = '0;
      case (cmd)
        CMD_ADC: add_with_carry(opnd);
        CMD_SBC: add_with_carry(~opnd);
        CMD_AND: a = nz(a & opnd);
        CMD_ORA: a = nz(a | opnd);
        CMD_EOR: a = nz(a ^ opnd);
        CMD_CMP: compare_with(a, opnd);
        CMD_CPX: compare_with(x, opnd);
        CMD_CPY: compare_with(y, opnd);
        CMD_BIT: begin
          p[FlagZ] = ((a & opnd) == 8'h00);
          p[FlagN] = opnd[7];
          p[FlagV] = opnd[6];
        end
        CMD_LDA: a = nz(opnd);
        CMD_LDX: x = nz(opnd);
        CMD_LDY: y = nz(opnd);
        CMD_STA: begin res.wdata = a; res.wvalid = 1'b1; end
        CMD_STX: begin res.wdata = x; res.wvalid = 1'b1; end
        CMD_STY: begin res.wdata = y; res.wvalid = 1'b1; end
        CMD_TAX: x = nz(a);
        CMD_TAY: y = nz(a);
        CMD_TXA: a = nz(x);
        CMD_TYA: a = nz(y);
        CMD_TSX: x = nz(sp);
        CMD_TXS: sp = x;
        CMD_INC, CMD_DEC, CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
          v = on_mem ? opnd : a;
          cin = p[FlagC];
          case (cmd)
            CMD_INC: v = v + 8'h01;
            CMD_DEC: v = v - 8'h01;
            CMD_ASL: begin p[FlagC] = v[7]; v = {v[6:0], 1'b0}; end
            CMD_LSR: begin p[FlagC] = v[0]; v = {1'b0, v[7:1]}; end
            CMD_ROL: begin p[FlagC] = v[7]; v = {v[6:0], cin}; end
            default: begin p[FlagC] = v[0]; v = {cin, v[7:1]}; end
          endcase
          v = nz(v);
          if (on_mem) begin
            res.wdata = v;
            res.wvalid = 1'b1;
          end else begin
            a = v;
          end
        end
        CMD_INX: x = nz(x + 8'h01);
        CMD_INY: y = nz(y + 8'h01);
        CMD_DEX: x = nz(x - 8'h01);
        CMD_DEY: y = nz(y - 8'h01);
        CMD_CLC: p[FlagC] = 1'b0;
        CMD_SEC: p[FlagC] = 1'b1;
        CMD_CLI: p[FlagI] = 1'b0;
        CMD_SEI: p[FlagI] = 1'b1;
        CMD_CLD: p[FlagD] = 1'b0;
        CMD_SED: p[FlagD] = 1'b1;
        CMD_CLV: p[FlagV] = 1'b0;
        CMD_PHA, CMD_PHP: begin
          // push stores at the current pointer, then the pointer drops
          res.wdata = (cmd == CMD_PHA) ? a : (p | 8'h30);
          res.wvalid = 1'b1;
          res.sacc = 1'b1;
          res.saddr = {1'b1, sp};
          sp = sp - 8'h01;
        end
        CMD_PLA, CMD_PLP: begin
          // pull raises the pointer first, then reads there
          sp = sp + 8'h01;
          res.sacc = 1'b1;
          res.saddr = {1'b1, sp};
          if (cmd == CMD_PLA) a = nz(opnd);
          else p = opnd;
        end
        CMD_BCC: res.taken = ~p[FlagC];
        CMD_BCS: res.taken = p[FlagC];
        CMD_BEQ: res.taken = p[FlagZ];
        CMD_BNE: res.taken = ~p[FlagZ];
        CMD_BMI: res.taken = p[FlagN];
        CMD_BPL: res.taken = ~p[FlagN];
        CMD_BVC: res.taken = ~p[FlagV];
        CMD_BVS: res.taken = p[FlagV];
        default: ;
      endcase
      p[FlagU] = 1'b1;
      p[FlagB] = 1'b0;
      if (!res.sacc) res.saddr = {1'b1, sp};
      res.flags = p;
      res.acc = a;
      res.index_x = x;
      res.index_y = y;
      owed_results.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < ReportMax)
          $display("result %0d: %s expected 0x%0h, got 0x%0h", result_idx, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] tdata);
      exec_result_t got, want;
      got = exec_result_t'(tdata);
      if (owed_results.size() == 0) begin
        if (errors < ReportMax)
          $display("result %0d: unexpected item 0x%0h", result_idx, tdata);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("write_data", want.wdata, got.wdata);
        check_field("write_valid", want.wvalid, got.wvalid);
        check_field("stack_access", want.sacc, got.sacc);
        check_field("stack_address", want.saddr, got.saddr);
        check_field("branch_taken", want.taken, got.taken);
        check_field("status_flags", want.flags, got.flags);
        check_field("accumulator_out", want.acc, got.acc);
        check_field("index_x_out", want.index_x, got.index_x);
        check_field("index_y_out", want.index_y, got.index_y);
      end
      result_idx++;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  cpu_state_model cpu_model = new();
  int unsigned tx_idle_pct = 22;
  int unsigned rx_stall_pct = 76;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  cpu8_alu_register_execute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one command item and hold it until the block takes it
  task automatic send_command(cmd_e cmd, logic [7:0] opnd, logic on_mem);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, on_mem, opnd, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    cpu_model.note_command(cmd, opnd, on_mem);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_commands(int unsigned count);
    cmd_e cmd;
    for (int unsigned i = 0; i < count; i++) begin
      // mostly defined operations, some unused codes
      if ($urandom_range(99) < 92) cmd = cmd_e'($urandom_range(CMD_BVS));
      else cmd = cmd_e'($urandom_range(63, CMD_BVS + 1));
      send_command(cmd, pick_operand(), 1'($urandom_range(1)));
    end
  endtask

  // Result side: check every taken item, stall at random, hold off once for long
  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        cpu_model.check_result(m_axis_tdata);
        results_seen++;
      end
      if (!held && results_seen >= 850) begin
        held = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // overflow, carry and wrap corners, stack rules, decimal flag, unused code
    send_command(CMD_LDA, 8'h00, 1'b0);
    send_command(CMD_LDA, 8'h7F, 1'b0);
    send_command(CMD_ADC, 8'h01, 1'b0);
    send_command(CMD_SBC, 8'hFF, 1'b0);
    send_command(CMD_SEC, 8'h00, 1'b0);
    send_command(CMD_SBC, 8'h80, 1'b0);
    send_command(CMD_LDX, 8'hFF, 1'b0);
    send_command(CMD_INX, 8'h00, 1'b0);
    send_command(CMD_DEY, 8'h00, 1'b0);
    send_command(CMD_CPX, 8'h00, 1'b0);
    send_command(CMD_CMP, 8'hFF, 1'b0);
    send_command(CMD_BIT, 8'hC0, 1'b0);
    send_command(CMD_ASL, 8'h00, 1'b0);
    send_command(CMD_ROR, 8'h01, 1'b1);
    send_command(CMD_INC, 8'hFF, 1'b1);
    send_command(CMD_DEC, 8'h00, 1'b0);
    send_command(CMD_LSR, 8'h80, 1'b1);
    send_command(CMD_PHP, 8'h00, 1'b0);
    send_command(CMD_PLP, 8'hFF, 1'b0);
    send_command(CMD_TXS, 8'h00, 1'b0);
    send_command(CMD_PHA, 8'h00, 1'b0);
    send_command(CMD_PLA, 8'h80, 1'b0);
    send_command(CMD_TSX, 8'h00, 1'b0);
    send_command(CMD_SED, 8'h00, 1'b0);
    send_command(CMD_ADC, 8'h99, 1'b0);
    send_command(CMD_BVS, 8'h00, 1'b0);
    send_command(cmd_e'(6'd63), 8'hFF, 1'b1);

    send_random_commands(350);
    tx_idle_pct = 76;
    rx_stall_pct = 22;
    send_random_commands(350);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random_commands(350);
    s_axis_tvalid <= 1'b0;

    while (cpu_model.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (cpu_model.errors == 0 && cpu_model.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/c8ae_pkg.sv
rtl/c8ae_alu.sv
rtl/cpu8_alu_register_execute.sv
rtl/c8ae_checker.sv
tb/cpu8_alu_register_execute_tb.sv
